// File: src/slm_pkg.sv
package slm_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MATRIX_WIDTH = 4;
  localparam int unsigned DEF_PIXEL_COUNT  = 16;

  // Fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned PIX_W  = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned RGB_W  = 3 * BYTE_W;
  // column holds x mod width, width up to 64
  localparam int unsigned COL_W  = 6;
  // y * width + column, y up to 255 and width up to 64
  localparam int unsigned IDX_W  = 15;
  localparam int unsigned BYTE_VALUES = 1 << BYTE_W;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STORED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LED      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PIXEL    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OOR      = 3'd5;

  // Byte positions inside a record
  localparam logic [POS_W-1:0] POS_X     = 3'd0;
  localparam logic [POS_W-1:0] POS_Y     = 3'd1;
  localparam logic [POS_W-1:0] POS_RED   = 3'd2;
  localparam logic [POS_W-1:0] POS_GREEN = 3'd3;
  localparam logic [POS_W-1:0] POS_BLUE  = 3'd4;

  typedef logic [COL_W-1:0] col_lut_t [BYTE_VALUES];

  // x mod w for every byte value, built with a wrapping counter
  function automatic col_lut_t col_table(input int unsigned w);
    col_lut_t         t;
    logic [COL_W-1:0] c;
    c = '0;
    for (int i = 0; i < BYTE_VALUES; i++) begin
      t[i] = c;
      if (int'(c) == int'(w) - 1) begin
        c = '0;
      end else begin
        c = c + 1'b1;
      end
    end
    return t;
  endfunction

  typedef struct packed {
    logic             load_count;
    logic             store_byte;
    logic             finish_record;
    logic             read_pixel;
    logic             emit_pixel;
    logic [POS_W-1:0] byte_pos;
  } cmd_t;

  typedef struct packed {
    logic count_ok;
    logic frame_done;
    logic dump_last;
    logic slot_free;
  } sts_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIX_W-1:0]  pixel_index;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [CNT_W-1:0]  leds_done;
    logic              last;
  } res_t;

endpackage

// File: src/slm_if.sv
interface slm_rx_if;
  logic                      valid;
  logic                      ready;
  logic [slm_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slm_res_if;
  logic                       valid;
  logic                       ready;
  logic [slm_pkg::KIND_W-1:0] kind;
  logic [slm_pkg::PIX_W-1:0]  pixel_index;
  logic [slm_pkg::BYTE_W-1:0] red;
  logic [slm_pkg::BYTE_W-1:0] green;
  logic [slm_pkg::BYTE_W-1:0] blue;
  logic [slm_pkg::CNT_W-1:0]  leds_done;
  logic                       last;

  modport source (output valid, output kind, output pixel_index, output red,
                  output green, output blue, output leds_done, output last,
                  input ready);
  modport sink (input valid, input kind, input pixel_index, input red,
                input green, input blue, input leds_done, input last,
                output ready);
endinterface

// File: src/serial_led_matrix_frame_loader.sv
// Serpentine LED matrix frame loader.
//
// rx_i (sink) takes one byte per item. While waiting for a count, a byte gives
// the number of LED records to follow; zero or more than PIXEL_COUNT is
// rejected. Each record is five bytes: x, y, red, green, blue. The record maps
// to a pixel index with even rows reversed and odd rows forward, and its
// color goes into the frame store (off-matrix indexes are reported and dropped).
// res_o (source) carries the results, one per byte, plus the whole frame after
// the last record.
// A result appears in the output register the cycle after its byte is
// accepted. Count and record bytes go at one byte per cycle while res_o
// keeps up. After the final record the frame dump reads each pixel through
// the single read port of the frame store, then loads it into the output
// register; rx_i.ready stays low for the whole dump.
// When res_o stalls, the pending result holds and rx_i.ready drops until the
// output register frees up.
// Reset returns the block to waiting for a count and clears the frame store
// valid bits at once; no clearing pass is needed. The same happens at dump end.
module serial_led_matrix_frame_loader #(
  parameter int unsigned MATRIX_WIDTH = slm_pkg::DEF_MATRIX_WIDTH,
  parameter int unsigned PIXEL_COUNT  = slm_pkg::DEF_PIXEL_COUNT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slm_rx_if.sink    rx_i,
  slm_res_if.source res_o
);
  import slm_pkg::*;

  cmd_t cmd;    // controller -> datapath
  sts_t sts;    // datapath -> controller
  res_t res;
  logic out_valid;

  // sequencer: count / record byte tracking and the dump loop
  slm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // record registers, index math, frame store and the output register
  slm_datapath #(
    .MATRIX_WIDTH (MATRIX_WIDTH),
    .PIXEL_COUNT  (PIXEL_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_i.rx_byte),
    .out_ready_i (res_o.ready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign res_o.valid       = out_valid;
  assign res_o.kind        = res.kind;
  assign res_o.pixel_index = res.pixel_index;
  assign res_o.red         = res.red;
  assign res_o.green       = res.green;
  assign res_o.blue        = res.blue;
  assign res_o.leds_done   = res.leds_done;
  assign res_o.last        = res.last;

endmodule

// File: src/slm_ctrl.sv
module slm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  slm_pkg::sts_t sts_i,
  output slm_pkg::cmd_t cmd_o
);
  import slm_pkg::*;

  localparam logic [1:0] ST_COUNT = 2'd0;
  localparam logic [1:0] ST_REC   = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             accept;

  always_comb begin
    in_ready_o   = ((state_q == ST_COUNT) || (state_q == ST_REC)) && sts_i.slot_free;
    accept       = in_valid_i && in_ready_o;
    cmd_o        = '0;
    cmd_o.byte_pos = pos_q;
    state_d      = state_q;
    pos_d        = pos_q;
    case (state_q)
      ST_COUNT: begin
        if (accept) begin
          cmd_o.load_count = 1'b1;
          if (sts_i.count_ok) begin
            state_d = ST_REC;
            pos_d   = POS_X;
          end
        end
      end
      ST_REC: begin
        if (accept) begin
          if (pos_q != POS_BLUE) begin
            cmd_o.store_byte = 1'b1;
            pos_d            = pos_q + 1'b1;
          end else begin
            cmd_o.finish_record = 1'b1;
            pos_d               = POS_X;
            if (sts_i.frame_done) begin
              state_d = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        cmd_o.read_pixel = 1'b1;
        state_d          = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_pixel = 1'b1;
          state_d          = sts_i.dump_last ? ST_COUNT : ST_READ;
        end
      end
      default: begin
        state_d = ST_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COUNT;
      pos_q   <= POS_X;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  // frame end hands over to the dump
  a_dump_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish_record && sts_i.frame_done |=> state_q == ST_READ)
    else $error("dump did not start after last record");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_BLUE)
    else $error("record byte position out of range");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && !sts_i.slot_free |=> state_q == ST_EMIT)
    else $error("pixel skipped while output stalled");

endmodule

// File: src/slm_datapath.sv
module slm_datapath #(
  parameter int unsigned MATRIX_WIDTH = slm_pkg::DEF_MATRIX_WIDTH,
  parameter int unsigned PIXEL_COUNT  = slm_pkg::DEF_PIXEL_COUNT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [slm_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                       out_ready_i,
  input  slm_pkg::cmd_t              cmd_i,
  output slm_pkg::sts_t              sts_o,
  output logic                       out_valid_o,
  output slm_pkg::res_t              res_o
);
  import slm_pkg::*;

  localparam int unsigned AW    = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned CMP_W = BYTE_W + 1;
  localparam col_lut_t    ColLut = col_table(MATRIX_WIDTH);

  // record fields kept between bytes
  logic [COL_W-1:0]  col_q;
  logic [IDX_W-1:0]  row_base_q;
  logic              y_odd_q;
  logic [BYTE_W-1:0] red_q, green_q;

  logic [CNT_W-1:0]  target_q, done_q;
  logic [AW-1:0]     addr_q;

  // frame store, entries not yet written since the last clear read as zero
  logic [RGB_W-1:0]       mem_q [PIXEL_COUNT];
  logic [PIXEL_COUNT-1:0] valid_q;
  logic [RGB_W-1:0]       rd_data_q;
  logic                   rd_valid_q;

  res_t res_q, res_d;
  logic out_valid_q, load;

  logic [CNT_W-1:0] done_inc;
  logic [COL_W-1:0] offset;
  logic [IDX_W-1:0] idx;
  logic             in_range;

  always_comb begin
    done_inc = done_q + 1'b1;
    offset   = y_odd_q ? col_q : (COL_W'(MATRIX_WIDTH - 1) - col_q);
    idx      = row_base_q + IDX_W'(offset);
    in_range = idx < IDX_W'(PIXEL_COUNT);

    sts_o.count_ok   = (rx_byte_i != '0) &&
                       ({1'b0, rx_byte_i} <= CMP_W'(PIXEL_COUNT));
    sts_o.frame_done = done_inc >= target_q;
    sts_o.dump_last  = addr_q == AW'(PIXEL_COUNT - 1);
    sts_o.slot_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    res_d = res_q;
    load  = 1'b0;
    if (cmd_i.load_count) begin
      load           = 1'b1;
      res_d          = '0;
      res_d.kind     = sts_o.count_ok ? KIND_ACCEPTED : KIND_REJECTED;
      res_d.leds_done = sts_o.count_ok ? '0 : done_q;
      res_d.last     = 1'b1;
    end else if (cmd_i.store_byte) begin
      load            = 1'b1;
      res_d           = '0;
      res_d.kind      = KIND_STORED;
      res_d.leds_done = done_q;
      res_d.last      = 1'b1;
    end else if (cmd_i.finish_record) begin
      load              = 1'b1;
      res_d.kind        = in_range ? KIND_LED : KIND_OOR;
      res_d.pixel_index = in_range ? idx[PIX_W-1:0] : '0;
      res_d.red         = red_q;
      res_d.green       = green_q;
      res_d.blue        = rx_byte_i;
      res_d.leds_done   = done_inc;
      res_d.last        = !sts_o.frame_done;
    end else if (cmd_i.emit_pixel) begin
      load              = 1'b1;
      res_d.kind        = KIND_PIXEL;
      res_d.pixel_index = PIX_W'(addr_q);
      {res_d.red, res_d.green, res_d.blue} = rd_valid_q ? rd_data_q : '0;
      res_d.leds_done   = done_q;
      res_d.last        = sts_o.dump_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      target_q    <= '0;
      done_q      <= '0;
      addr_q      <= '0;
      valid_q     <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_count && sts_o.count_ok) begin
        target_q <= rx_byte_i[CNT_W-1:0];
        done_q   <= '0;
      end else if (cmd_i.finish_record) begin
        done_q <= done_inc;
      end
      if (cmd_i.finish_record && in_range) begin
        valid_q[idx[AW-1:0]] <= 1'b1;
      end
      if (cmd_i.emit_pixel) begin
        addr_q <= sts_o.dump_last ? '0 : addr_q + 1'b1;
        if (sts_o.dump_last) begin
          valid_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.store_byte) begin
      case (cmd_i.byte_pos)
        POS_X:     col_q <= ColLut[rx_byte_i];
        POS_Y: begin
          row_base_q <= IDX_W'(rx_byte_i) * IDX_W'(MATRIX_WIDTH);
          y_odd_q    <= rx_byte_i[0];
        end
        POS_RED:   red_q   <= rx_byte_i;
        POS_GREEN: green_q <= rx_byte_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_record && in_range) begin
      mem_q[idx[AW-1:0]] <= {red_q, green_q, rx_byte_i};
    end
    if (cmd_i.read_pixel) begin
      rd_data_q  <= mem_q[addr_q];
      rd_valid_q <= valid_q[addr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_pixel |-> sts_o.slot_free)
    else $error("pixel loaded over a pending result");

  a_clear_after_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_pixel && sts_o.dump_last |=> valid_q == '0 && addr_q == '0)
    else $error("frame store not cleared after dump");

  a_led_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish_record && in_range |=> valid_q != '0)
    else $error("written pixel not marked valid");

endmodule
